FILE: hdl/heap_sort_engine_macros.svh
// ----------------------------------------------------------------------------
// heap sort engine assertion macros
// concurrent checks on the local clock and reset, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef HEAP_SORT_ENGINE_MACROS_SVH
`define HEAP_SORT_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock outside reset
`define HSE_ASSERT_ON(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// condition must never be seen outside reset
`define HSE_ASSERT_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`else

`define HSE_ASSERT_ON(name, prop, msg)

`define HSE_ASSERT_NEVER(name, cond, msg)

`endif

`endif

FILE: hdl/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// shared constants, types and helpers of the heap sort engine
// ----------------------------------------------------------------------------
package hse_pkg;

   // sizes
   localparam int DATA_W      = 32;
   localparam int STORE_DEPTH = 64;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   // heap child index reaches twice the depth
   localparam int ADR_W       = IDX_W + 2;

   typedef logic signed [DATA_W-1:0] value_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [ADR_W-1:0]         adr_type;

   // store write and sort start from the front end
   typedef struct packed {
      logic      valid;
      idx_type   addr;
      value_type value;
      logic      start;
      cnt_type   count;
   } hse_load_type;

   // one sorted value toward the output register
   typedef struct packed {
      logic      valid;
      value_type value;
      logic      last;
   } hse_emit_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BUILD_RD,
      ST_BUILD_GET,
      ST_SIFT,
      ST_SIFT_PUT,
      ST_SWAP_RD,
      ST_SWAP_WR,
      ST_EMIT_RD,
      ST_EMIT_LD
   } hse_state_type;

   // left child of a heap node
   function automatic adr_type child_of(idx_type node);
      child_of = {1'b0, node, 1'b1};
   endfunction

endpackage

FILE: hdl/hse_if.sv
// ----------------------------------------------------------------------------
// hse channel interfaces
// valid/ready channels for input values and sorted results
// ----------------------------------------------------------------------------

// input channel: one value per beat
interface hse_req_if import hse_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type sample_value;
   logic      set_end;

   modport source (output valid, output sample_value, output set_end, input ready);
   modport sink   (input valid, input sample_value, input set_end, output ready);
endinterface

// result channel: one sorted value per beat
interface hse_rsp_if import hse_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type sorted_value;
   logic      final_item;
   logic      overflow_seen;

   modport source (output valid, output sorted_value, output final_item,
                   output overflow_seen, input ready);
   modport sink   (input valid, input sorted_value, input final_item,
                   input overflow_seen, output ready);
endinterface

FILE: hdl/heap_sort_engine.sv
// ----------------------------------------------------------------------------
// heap_sort_engine
// collects signed values into sets and returns each set sorted ascending
// ----------------------------------------------------------------------------
// Usage: every req_chan beat carries one sample_value; a beat with set_end
// high closes the set and starts the sort. Up to 64 values are held; later
// values of the set are dropped and overflow_seen is high on every result
// of that set. rsp_chan returns the set one value per beat, smallest first,
// with final_item high on the last one.
// Timing: a value beat is taken whenever the core is idle. A set of n values
// sorts in place in one shared store with one write port, one sift level per
// cycle, through the heap build and then the tail swaps; each result is read
// out through a read state and then a load state.
// req_chan.ready is low from the set end beat until the last result is
// loaded into the output register. A stalled rsp_chan holds that register
// and pauses the read-out; the next set can load while the last result
// still waits.
// Reset clears the fill count, the drop flag, the sequencer and the output
// valid; the store itself needs no clearing.
// ----------------------------------------------------------------------------
`include "heap_sort_engine_macros.svh"

module heap_sort_engine import hse_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hse_req_if.sink    req_chan,
   hse_rsp_if.source  rsp_chan
);

   cnt_type      fill_ff, fill_in;
   logic         dropped_ff, dropped_in;
   logic         rsp_valid_ff, rsp_valid_in;
   value_type    rsp_value_ff;
   logic         rsp_final_ff;
   logic         rsp_ovf_ff;
   logic         accept;
   logic         has_room;
   logic         core_idle;
   logic         emit_take;
   logic         set_done;
   hse_load_type load;
   hse_emit_type emit;

   hse_sort_core u_core (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .idle      (core_idle),
      .emit      (emit),
      .emit_take (emit_take)
   );

   // input beat into the store
   always_comb begin
      accept     = req_chan.valid && req_chan.ready;
      has_room   = fill_ff < cnt_type'(STORE_DEPTH);
      load.valid = accept && has_room;
      load.addr  = fill_ff[IDX_W-1:0];
      load.value = req_chan.sample_value;
      load.start = accept && req_chan.set_end;
      load.count = has_room ? (fill_ff + cnt_type'(1)) : fill_ff;
   end

   assign req_chan.ready = core_idle;

   // fill count and drop flag live until the set is emitted
   assign emit_take = !rsp_valid_ff || rsp_chan.ready;
   assign set_done  = emit.valid && emit_take && emit.last;

   always_comb begin
      fill_in    = fill_ff;
      dropped_in = dropped_ff;
      if (set_done) begin
         fill_in    = '0;
         dropped_in = 1'b0;
      end else if (load.valid) begin
         fill_in = fill_ff + cnt_type'(1);
      end else if (accept) begin
         dropped_in = 1'b1;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid && emit_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit.valid && emit_take) begin
         rsp_value_ff <= emit.value;
         rsp_final_ff <= emit.last;
         rsp_ovf_ff   <= dropped_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.sorted_value  = rsp_value_ff;
   assign rsp_chan.final_item    = rsp_final_ff;
   assign rsp_chan.overflow_seen = rsp_ovf_ff;

   `HSE_ASSERT_ON(a_fill_bound, fill_ff <= cnt_type'(STORE_DEPTH), "fill count beyond store depth")
   `HSE_ASSERT_ON(a_drop_only_full, $rose(dropped_ff) |-> ($past(fill_ff) == cnt_type'(STORE_DEPTH)), "value dropped with room left")
   `HSE_ASSERT_ON(a_emit_lands, (emit.valid && emit_take) |=> rsp_valid_ff, "sorted value lost before output")

endmodule

FILE: hdl/hse_sort_core.sv
// ----------------------------------------------------------------------------
// hse_sort_core
// value store with a sequencer that heap sorts it in place, one sift level
// per cycle, and then reads the values out in ascending order
// ----------------------------------------------------------------------------
`include "heap_sort_engine_macros.svh"

module hse_sort_core import hse_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  hse_load_type load,
   output logic         idle,
   output hse_emit_type emit,
   input  logic         emit_take
);

   // value store, two read ports and one write port
   value_type mem [STORE_DEPTH];
   value_type rd_a_ff;
   value_type rd_b_ff;
   idx_type   addr_a;
   idx_type   addr_b;
   logic      mem_we;
   idx_type   mem_wa;
   value_type mem_wd;

   hse_state_type state_ff, state_in;
   cnt_type       count_ff, count_in;
   idx_type       parent_ff, parent_in;
   idx_type       tail_ff, tail_in;
   idx_type       node_ff, node_in;
   cnt_type       sift_len_ff, sift_len_in;
   value_type     hold_ff, hold_in;
   logic          extract_ff, extract_in;
   idx_type       out_idx_ff, out_idx_in;

   adr_type   par_child;
   adr_type   node_child;
   adr_type   root_child;
   adr_type   big_adr;
   idx_type   big_idx;
   adr_type   big_child;
   adr_type   len_ext;
   logic      pick_b;
   value_type larger;
   logic      move;
   logic      sift_done;
   logic      emit_last;

   // store access
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         extract_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         extract_ff <= extract_in;
      end
      count_ff    <= count_in;
      parent_ff   <= parent_in;
      tail_ff     <= tail_in;
      node_ff     <= node_in;
      sift_len_ff <= sift_len_in;
      hold_ff     <= hold_in;
      out_idx_ff  <= out_idx_in;
   end

   // sift compare: larger child against the held value
   always_comb begin
      par_child  = child_of(parent_ff);
      node_child = child_of(node_ff);
      root_child = child_of(idx_type'(0));
      len_ext    = adr_type'(sift_len_ff);
      pick_b     = ((node_child + adr_type'(1)) < len_ext) && (rd_a_ff < rd_b_ff);
      larger     = pick_b ? rd_b_ff : rd_a_ff;
      big_adr    = pick_b ? (node_child + adr_type'(1)) : node_child;
      big_idx    = big_adr[IDX_W-1:0];
      big_child  = child_of(big_idx);
      move       = hold_ff < larger;
      emit_last  = (cnt_type'(out_idx_ff) + cnt_type'(1)) == count_ff;
   end

   // next state and store control
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      parent_in   = parent_ff;
      tail_in     = tail_ff;
      node_in     = node_ff;
      sift_len_in = sift_len_ff;
      hold_in     = hold_ff;
      extract_in  = extract_ff;
      out_idx_in  = out_idx_ff;
      mem_we      = 1'b0;
      mem_wa      = node_ff;
      mem_wd      = hold_ff;
      addr_a      = out_idx_ff;
      addr_b      = tail_ff;
      sift_done   = 1'b0;
      emit.valid  = 1'b0;
      emit.value  = rd_a_ff;
      emit.last   = emit_last;

      case (state_ff)
         ST_IDLE: begin
            mem_we = load.valid;
            mem_wa = load.addr;
            mem_wd = load.value;
            if (load.start) begin
               count_in   = load.count;
               extract_in = 1'b0;
               out_idx_in = '0;
               parent_in  = idx_type'((load.count - cnt_type'(1)) >> 1);
               if (load.count < cnt_type'(2)) begin
                  state_in = ST_EMIT_RD;
               end else begin
                  state_in = ST_BUILD_RD;
               end
            end
         end
         ST_BUILD_RD: begin
            addr_a   = parent_ff;
            state_in = ST_BUILD_GET;
         end
         ST_BUILD_GET: begin
            hold_in     = rd_a_ff;
            node_in     = parent_ff;
            sift_len_in = count_ff;
            addr_a      = par_child[IDX_W-1:0];
            addr_b      = (par_child[IDX_W-1:0] + idx_type'(1));
            if (par_child < adr_type'(count_ff)) begin
               state_in = ST_SIFT;
            end else begin
               state_in = ST_SIFT_PUT;
            end
         end
         ST_SIFT: begin
            mem_we = 1'b1;
            mem_wa = node_ff;
            if (!move) begin
               mem_wd    = hold_ff;
               sift_done = 1'b1;
            end else begin
               mem_wd  = larger;
               node_in = big_idx;
               addr_a  = big_child[IDX_W-1:0];
               addr_b  = (big_child[IDX_W-1:0] + idx_type'(1));
               if (big_child >= len_ext) begin
                  state_in = ST_SIFT_PUT;
               end
            end
         end
         ST_SIFT_PUT: begin
            mem_we    = 1'b1;
            mem_wa    = node_ff;
            mem_wd    = hold_ff;
            sift_done = 1'b1;
         end
         ST_SWAP_RD: begin
            addr_a   = '0;
            addr_b   = tail_ff;
            state_in = ST_SWAP_WR;
         end
         ST_SWAP_WR: begin
            // old root goes to the tail, old tail is sifted from the root
            mem_we      = 1'b1;
            mem_wa      = tail_ff;
            mem_wd      = rd_a_ff;
            hold_in     = rd_b_ff;
            node_in     = '0;
            sift_len_in = cnt_type'(tail_ff);
            addr_a      = root_child[IDX_W-1:0];
            addr_b      = (root_child[IDX_W-1:0] + idx_type'(1));
            if (tail_ff > idx_type'(1)) begin
               state_in = ST_SIFT;
            end else begin
               state_in = ST_SIFT_PUT;
            end
         end
         ST_EMIT_RD: begin
            addr_a   = out_idx_ff;
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            addr_a     = out_idx_ff;
            emit.valid = 1'b1;
            if (emit_take) begin
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + idx_type'(1);
                  state_in   = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // next sift: previous parent, next tail swap, or read-out
      if (sift_done) begin
         if (!extract_ff) begin
            if (parent_ff != '0) begin
               parent_in = parent_ff - idx_type'(1);
               state_in  = ST_BUILD_RD;
            end else begin
               extract_in = 1'b1;
               tail_in    = idx_type'(count_ff - cnt_type'(1));
               state_in   = ST_SWAP_RD;
            end
         end else if (tail_ff == idx_type'(1)) begin
            out_idx_in = '0;
            state_in   = ST_EMIT_RD;
         end else begin
            tail_in  = tail_ff - idx_type'(1);
            state_in = ST_SWAP_RD;
         end
      end
   end

   assign idle = (state_ff == ST_IDLE);

   `HSE_ASSERT_ON(a_sift_child_in_heap, (state_ff == ST_SIFT) |-> (node_child < len_ext), "sift without child in heap")
   `HSE_ASSERT_ON(a_sift_len_bound, ((state_ff == ST_SIFT) || (state_ff == ST_SIFT_PUT)) |-> ((sift_len_ff <= count_ff) && (sift_len_ff != '0)), "sift length out of range")
   `HSE_ASSERT_ON(a_last_beat_idle, (emit.valid && emit_take && emit.last) |=> (state_ff == ST_IDLE), "no return to idle after last beat")
   `HSE_ASSERT_NEVER(a_start_while_busy, load.start && (state_ff != ST_IDLE), "set end taken while sorting")

endmodule
